// ----- rtl/core/integer_to_ascii_formatter_top_assert.svh -----
// ---------------------------------------------------------------------------
// Integer-to-ASCII formatter assertion macros
// Shared property forms for the formatter checks, clocked on clk_i and
// disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH

// same-cycle implication
`define ITOAF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("itoaf: same-cycle check failed");

// next-cycle implication
`define ITOAF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("itoaf: next-cycle check failed");

`endif

// ----- rtl/core/itoaf_pkg.sv -----
// ---------------------------------------------------------------------------
// Integer-to-ASCII formatter package
// Sizes, field positions, flag bits, character codes and the digit-to-ASCII
// mapping shared by the formatter modules.
// ---------------------------------------------------------------------------
package itoaf_pkg;

  localparam int VALUE_BITS = 64;
  localparam int MAX_CHARS  = 64;
  localparam int NCELL      = VALUE_BITS;

  localparam int DIG_W  = 6;
  localparam int BASE_W = 6;
  localparam int FMT_W  = 7;
  localparam int FLG_W  = 7;
  localparam int SZ_W   = FMT_W + 2;
  localparam int LEN_W  = 8;
  localparam int CNT_W  = $clog2(VALUE_BITS + NCELL);
  localparam int ND_W   = $clog2(NCELL + 1);
  localparam int POS_W  = $clog2(MAX_CHARS);

  localparam int IN_TDATA_W   = 96;
  localparam int RADIX_LSB    = 64;
  localparam int MIN_WID_LSB  = RADIX_LSB + BASE_W;
  localparam int MIN_DIG_LSB  = MIN_WID_LSB + FMT_W;
  localparam int FLAGS_LSB    = MIN_DIG_LSB + FMT_W;

  localparam int FLG_LEFT  = 0;
  localparam int FLG_ZPAD  = 1;
  localparam int FLG_SIGN  = 2;
  localparam int FLG_PLUS  = 3;
  localparam int FLG_SPACE = 4;
  localparam int FLG_ALT   = 5;
  localparam int FLG_UPPER = 6;

  localparam int TUSER_TRUNC = 0;
  localparam int TUSER_BAD   = 1;

  localparam logic [BASE_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [BASE_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [BASE_W-1:0] RADIX_OCT = 6'd8;
  localparam logic [BASE_W-1:0] RADIX_HEX = 6'd16;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic upper);
    logic [7:0] d8;
    d8 = 8'(d);
    if (d < DIG_W'(10)) begin
      digit_char = CH_ZERO + d8;
    end else begin
      digit_char = (upper ? CH_UA : CH_LA) + d8 - 8'd10;
    end
  endfunction

endpackage

// ----- rtl/core/itoaf_cell.sv -----
// ---------------------------------------------------------------------------
// Formatter digit cell
// Holds one digit. Takes a serial bit stream MSB first, keeps the running
// remainder by the radix and passes the quotient bits to the next cell.
// Shifts its digit upward on request.
// ---------------------------------------------------------------------------
module itoaf_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  itoaf_pkg::cell_ctrl_t      ctrl_i,
  input  logic [itoaf_pkg::BASE_W-1:0] base_i,
  input  logic                       vld_i,
  input  logic                       bit_i,
  input  logic [itoaf_pkg::DIG_W-1:0] dig_i,
  output logic                       vld_o,
  output logic                       bit_o,
  output logic [itoaf_pkg::DIG_W-1:0] dig_o
);
  import itoaf_pkg::*;

  logic [DIG_W-1:0] dig_q;
  logic             vld_q;
  logic             bit_q;
  logic [DIG_W:0]   acc;
  logic [DIG_W:0]   rem;
  logic             ge;

  assign acc = {dig_q, bit_i};
  assign ge  = acc >= {1'b0, base_i};
  assign rem = acc - {1'b0, base_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= vld_i & ge;
    if (ctrl_i.clr) begin
      dig_q <= '0;
    end else if (vld_i) begin
      dig_q <= ge ? rem[DIG_W-1:0] : acc[DIG_W-1:0];
    end else if (ctrl_i.shift) begin
      dig_q <= dig_i;
    end
  end

  assign vld_o = vld_q;
  assign bit_o = bit_q;
  assign dig_o = dig_q;

endmodule

// ----- rtl/core/itoaf_chain.sv -----
// ---------------------------------------------------------------------------
// Formatter digit chain
// Row of digit cells, cell 0 holding the least significant digit. Quotient
// bits ripple one cell per cycle; digits shift toward the top cell.
// ---------------------------------------------------------------------------
module itoaf_chain (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  itoaf_pkg::cell_ctrl_t        ctrl_i,
  input  logic [itoaf_pkg::BASE_W-1:0] base_i,
  input  logic                         vld_i,
  input  logic                         bit_i,
  output logic [itoaf_pkg::DIG_W-1:0]  top_dig_o
);
  import itoaf_pkg::*;

  logic             vld_w [NCELL+1];
  logic             bit_w [NCELL+1];
  logic [DIG_W-1:0] dig_w [NCELL+1];

  assign vld_w[0] = vld_i;
  assign bit_w[0] = bit_i;
  assign dig_w[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    itoaf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_i),
      .base_i (base_i),
      .vld_i  (vld_w[i]),
      .bit_i  (bit_w[i]),
      .dig_i  (dig_w[i]),
      .vld_o  (vld_w[i+1]),
      .bit_o  (bit_w[i+1]),
      .dig_o  (dig_w[i+1])
    );
  end

  assign top_dig_o = dig_w[NCELL];

endmodule

// ----- rtl/core/integer_to_ascii_formatter_top.sv -----
// ---------------------------------------------------------------------------
// Integer-to-ASCII formatter
// One printf-style integer conversion per input item; the formatted field
// leaves as one character per output item, the final one marked by tlast.
//
//   channel   | dir | tdata                               | tlast | tuser
//   s_axis    | in  | value, radix, min_width, min_digits,| -     | -
//             |     | format_flags                        |       |
//   m_axis    | out | ch                                  | last  | truncated, bad_radix
//
// Each item runs conversion through the digit chain, normalizing to the top
// cell, layout in ST_CALC and ST_BND, and one output item per emitted
// character (up to MAX_CHARS), then re-enters idle. A bad radix skips to
// ST_ERR and yields one NUL character. Reset clears all control state at once.
// A stalled m_axis holds the current character and freezes emission.
// ---------------------------------------------------------------------------
module integer_to_ascii_formatter_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [63:0] value, [69:64] radix, [76:70] min_width, [83:77] min_digits,
  // [90:84] format_flags, [95:91] zero
  input  logic [itoaf_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] ch
  output logic [7:0]                       m_axis_tdata,
  output logic                             m_axis_tlast,
  // [0] truncated, [1] bad_radix
  output logic [1:0]                       m_axis_tuser
);
  import itoaf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_CALC,
    ST_BND,
    ST_EMIT,
    ST_ERR
  } state_e;

  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_BITS + NCELL - 1);
  localparam logic [CNT_W-1:0] NORM_LAST = CNT_W'(NCELL - 1);

  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [VALUE_BITS-1:0] mag_q;
  logic [BASE_W-1:0] base_q;
  logic              upper_q;
  logic              left_q;
  logic              zp_q;
  logic [7:0]        sign_q;
  logic              sgn_len_q;
  logic [1:0]        pfx_len_q;
  logic [FMT_W-1:0]  mw_q;
  logic [FMT_W-1:0]  prec_q;
  logic [ND_W-1:0]   nd_q;
  logic [FMT_W-1:0]  pw_q;
  logic [FMT_W-1:0]  s_q;
  logic [LEN_W-1:0]  b1_q, b2_q, b3_q, b4_q, b5_q;
  logic              trunc_q;
  logic [POS_W-1:0]  pos_q;
  logic [POS_W-1:0]  lastpos_q;
  logic              m_valid_q;
  logic              m_valid_d;
  logic [7:0]        m_data_q;
  logic              m_last_q;
  logic [1:0]        m_user_q;

  logic                  accept;
  logic                  out_free;
  logic [VALUE_BITS-1:0] in_val;
  logic [BASE_W-1:0]     in_radix;
  logic [FLG_W-1:0]      in_flags;
  logic                  in_neg;
  logic                  in_left;
  logic [DIG_W-1:0]      top_dig;
  cell_ctrl_t            cell_ctl;
  logic                  conv_vld;
  logic                  norm_more;
  logic [LEN_W-1:0]      p;
  logic                  in_digits;
  logic [7:0]            emit_ch;
  logic [FMT_W-1:0]      pw_c;
  logic signed [SZ_W-1:0] size_c;
  logic [LEN_W-1:0]      lead_c, zeros_c, trail_c;
  logic [LEN_W-1:0]      b1_c, b2_c, b3_c, b4_c, b5_c, tot_c;
  logic                  trunc_c;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign in_val   = s_axis_tdata[VALUE_BITS-1:0];
  assign in_radix = s_axis_tdata[RADIX_LSB +: BASE_W];
  assign in_flags = s_axis_tdata[FLAGS_LSB +: FLG_W];
  assign in_neg   = in_flags[FLG_SIGN] && in_val[VALUE_BITS-1];
  assign in_left  = in_flags[FLG_LEFT];

  assign m_valid_d = (out_free && ((state_q == ST_EMIT) || (state_q == ST_ERR))) ||
                     (m_valid_q && !m_axis_tready);

  assign conv_vld  = (state_q == ST_CONV) && (cnt_q < CNT_W'(VALUE_BITS));
  assign norm_more = (top_dig == '0) && (cnt_q != NORM_LAST);

  assign p         = LEN_W'(pos_q);
  assign in_digits = (p >= b4_q) && (p < b5_q);

  always_comb begin
    if (p < b1_q) begin
      emit_ch = CH_SPACE;
    end else if (p < b2_q) begin
      emit_ch = sign_q;
    end else if (p < b3_q) begin
      emit_ch = (p == b2_q) ? CH_ZERO : (upper_q ? CH_UX : CH_LX);
    end else if (p < b4_q) begin
      emit_ch = CH_ZERO;
    end else if (p < b5_q) begin
      emit_ch = digit_char(top_dig, upper_q);
    end else begin
      emit_ch = CH_SPACE;
    end
  end

  always_comb begin
    cell_ctl.clr   = accept;
    cell_ctl.shift = ((state_q == ST_NORM) && norm_more) ||
                     ((state_q == ST_EMIT) && out_free && in_digits);
  end

  always_comb begin
    pw_c    = (FMT_W'(nd_q) > prec_q) ? FMT_W'(nd_q) : prec_q;
    size_c  = $signed({2'b00, mw_q}) - $signed(SZ_W'(sgn_len_q))
            - $signed(SZ_W'(pfx_len_q)) - $signed({2'b00, pw_c});
    lead_c  = (!zp_q && !left_q) ? LEN_W'(s_q) : '0;
    zeros_c = (zp_q ? LEN_W'(s_q) : '0) + LEN_W'(pw_q) - LEN_W'(nd_q);
    trail_c = left_q ? LEN_W'(s_q) : '0;
    b1_c    = lead_c;
    b2_c    = b1_c + LEN_W'(sgn_len_q);
    b3_c    = b2_c + LEN_W'(pfx_len_q);
    b4_c    = b3_c + zeros_c;
    b5_c    = b4_c + LEN_W'(nd_q);
    tot_c   = b5_c + trail_c;
    trunc_c = tot_c > LEN_W'(MAX_CHARS);
  end

  itoaf_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (cell_ctl),
    .base_i    (base_q),
    .vld_i     (conv_vld),
    .bit_i     (mag_q[VALUE_BITS-1]),
    .top_dig_o (top_dig)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      mag_q     <= '0;
      base_q    <= '0;
      upper_q   <= 1'b0;
      left_q    <= 1'b0;
      zp_q      <= 1'b0;
      sign_q    <= CH_NUL;
      sgn_len_q <= 1'b0;
      pfx_len_q <= '0;
      mw_q      <= '0;
      prec_q    <= '0;
      nd_q      <= '0;
      pw_q      <= '0;
      s_q       <= '0;
      b1_q      <= '0;
      b2_q      <= '0;
      b3_q      <= '0;
      b4_q      <= '0;
      b5_q      <= '0;
      trunc_q   <= 1'b0;
      pos_q     <= '0;
      lastpos_q <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= CH_NUL;
      m_last_q  <= 1'b0;
      m_user_q  <= '0;
    end else begin
      m_valid_q <= m_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cnt_q     <= '0;
            mag_q     <= in_neg ? (~in_val + VALUE_BITS'(1)) : in_val;
            base_q    <= in_radix;
            upper_q   <= in_flags[FLG_UPPER];
            left_q    <= in_left;
            zp_q      <= in_flags[FLG_ZPAD] && !in_left;
            mw_q      <= s_axis_tdata[MIN_WID_LSB +: FMT_W];
            prec_q    <= s_axis_tdata[MIN_DIG_LSB +: FMT_W];
            sgn_len_q <= in_neg ||
                         (in_flags[FLG_SIGN] && (in_flags[FLG_PLUS] || in_flags[FLG_SPACE]));
            if (in_neg) begin
              sign_q <= CH_MINUS;
            end else if (in_flags[FLG_PLUS]) begin
              sign_q <= CH_PLUS;
            end else begin
              sign_q <= CH_SPACE;
            end
            if (in_flags[FLG_ALT] && in_radix == RADIX_HEX) begin
              pfx_len_q <= 2'd2;
            end else if (in_flags[FLG_ALT] && in_radix == RADIX_OCT) begin
              pfx_len_q <= 2'd1;
            end else begin
              pfx_len_q <= 2'd0;
            end
            state_q <= (in_radix inside {[RADIX_MIN:RADIX_MAX]}) ? ST_CONV : ST_ERR;
          end
        end
        ST_CONV: begin
          mag_q <= mag_q << 1;
          if (cnt_q == CONV_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_NORM;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_NORM: begin
          if (norm_more) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end else begin
            nd_q    <= ND_W'(NCELL) - ND_W'(cnt_q);
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          pw_q    <= pw_c;
          s_q     <= (size_c > 0) ? size_c[FMT_W-1:0] : '0;
          state_q <= ST_BND;
        end
        ST_BND: begin
          b1_q      <= b1_c;
          b2_q      <= b2_c;
          b3_q      <= b3_c;
          b4_q      <= b4_c;
          b5_q      <= b5_c;
          trunc_q   <= trunc_c;
          lastpos_q <= trunc_c ? POS_W'(MAX_CHARS - 1) : POS_W'(tot_c - LEN_W'(1));
          pos_q     <= '0;
          state_q   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            m_data_q  <= emit_ch;
            m_last_q  <= (pos_q == lastpos_q);
            m_user_q  <= {1'b0, trunc_q};
            if (pos_q == lastpos_q) begin
              state_q <= ST_IDLE;
            end else begin
              pos_q <= pos_q + POS_W'(1);
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            m_data_q  <= CH_NUL;
            m_last_q  <= 1'b1;
            m_user_q  <= 2'b10;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

`include "integer_to_ascii_formatter_top_assert.svh"

  `ITOAF_ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `ITOAF_ASSERT_IMP(a_err_item, m_axis_tvalid && m_axis_tuser[TUSER_BAD], m_axis_tlast && (m_axis_tdata == CH_NUL) && !m_axis_tuser[TUSER_TRUNC])
  `ITOAF_ASSERT_IMP(a_nd_nonzero, state_q == ST_CALC, nd_q != '0)
  `ITOAF_ASSERT_IMP(a_digit_range, (state_q == ST_EMIT) && cell_ctl.shift, top_dig < base_q)

endmodule

// ----- tb/integer_to_ascii_formatter_top_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Integer-to-ASCII formatter testbench
// Sends printf-style integer conversions on s_axis and checks every emitted
// character, its last mark and its truncated and bad-radix flags against a
// field builder kept in the bench. Directed items cover the field extremes,
// each flag, the prefixes, bad bases and the character cap. Random items
// then run under phases of sender idling and receiver stalling.
// ---------------------------------------------------------------------------
module integer_to_ascii_formatter_top_tb;
  import itoaf_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       truncated;
    logic       bad_radix;
  } fmt_char_t;

  localparam logic [FLG_W-1:0] F_NONE  = '0;
  localparam logic [FLG_W-1:0] F_LEFT  = FLG_W'(1 << FLG_LEFT);
  localparam logic [FLG_W-1:0] F_ZPAD  = FLG_W'(1 << FLG_ZPAD);
  localparam logic [FLG_W-1:0] F_SIGN  = FLG_W'(1 << FLG_SIGN);
  localparam logic [FLG_W-1:0] F_PLUS  = FLG_W'(1 << FLG_PLUS);
  localparam logic [FLG_W-1:0] F_SPACE = FLG_W'(1 << FLG_SPACE);
  localparam logic [FLG_W-1:0] F_ALT   = FLG_W'(1 << FLG_ALT);
  localparam logic [FLG_W-1:0] F_UPPER = FLG_W'(1 << FLG_UPPER);

  localparam logic [BASE_W-1:0] RADIX_DEC = 6'd10;
  localparam logic [BASE_W-1:0] RADIX_BIN = 6'd2;
  localparam logic [63:0]       MOST_NEG  = 64'h8000_0000_0000_0000;
  localparam int                DRAIN_CYCLES = 400;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;
  logic [1:0]            m_axis_tuser;

  fmt_char_t pending_chars[$];
  fmt_char_t want;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        n_items = 0;
  int        n_chars = 0;
  int        n_bad = 0;
  int        n_cut = 0;
  int        n_errors = 0;

  integer_to_ascii_formatter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void format_conversion(input logic [63:0] value,
                                            input logic [BASE_W-1:0] radix,
                                            input logic [FMT_W-1:0] min_width,
                                            input logic [FMT_W-1:0] min_digits,
                                            input logic [FLG_W-1:0] flags);
    logic [FLG_W-1:0] fl;
    logic [63:0]      mag;
    logic [63:0]      d;
    logic [7:0]       sign_ch;
    logic [7:0]       pad_ch;
    logic [7:0]       digits[$];
    logic [7:0]       field[$];
    int               room;
    int               prec;
    int               nd;
    int               n;
    bit               cut;
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      pending_chars.push_back('{ch: CH_NUL, last: 1'b1, truncated: 1'b0, bad_radix: 1'b1});
      n_bad++;
      return;
    end
    fl = flags;
    if (fl[FLG_LEFT]) fl[FLG_ZPAD] = 1'b0;
    pad_ch = fl[FLG_ZPAD] ? CH_ZERO : CH_SPACE;
    mag = value;
    room = int'(min_width);
    prec = int'(min_digits);
    sign_ch = CH_NUL;
    if (fl[FLG_SIGN]) begin
      if (mag[63]) begin
        sign_ch = CH_MINUS;
        mag = -mag;
        room--;
      end else if (fl[FLG_PLUS]) begin
        sign_ch = CH_PLUS;
        room--;
      end else if (fl[FLG_SPACE]) begin
        sign_ch = CH_SPACE;
        room--;
      end
    end
    if (fl[FLG_ALT]) begin
      if (radix == RADIX_HEX) room -= 2;
      else if (radix == RADIX_OCT) room--;
    end
    do begin
      d = mag % 64'(radix);
      if (d < 10) digits.push_front(CH_ZERO + 8'(d));
      else digits.push_front((fl[FLG_UPPER] ? CH_UA : CH_LA) + 8'(d) - 8'd10);
      mag = mag / 64'(radix);
    end while (mag != 0);
    nd = digits.size();
    if (nd > prec) prec = nd;
    room -= prec;
    if (!fl[FLG_ZPAD] && !fl[FLG_LEFT]) begin
      for (; room > 0; room--) field.push_back(CH_SPACE);
    end
    if (sign_ch != CH_NUL) field.push_back(sign_ch);
    if (fl[FLG_ALT] && radix == RADIX_OCT) field.push_back(CH_ZERO);
    if (fl[FLG_ALT] && radix == RADIX_HEX) begin
      field.push_back(CH_ZERO);
      field.push_back(fl[FLG_UPPER] ? CH_UX : CH_LX);
    end
    if (!fl[FLG_LEFT]) begin
      for (; room > 0; room--) field.push_back(pad_ch);
    end
    for (int k = nd; k < prec; k++) field.push_back(CH_ZERO);
    foreach (digits[k]) field.push_back(digits[k]);
    for (; room > 0; room--) field.push_back(CH_SPACE);
    cut = field.size() > MAX_CHARS;
    n = cut ? MAX_CHARS : field.size();
    if (cut) n_cut++;
    for (int k = 0; k < n; k++) begin
      pending_chars.push_back('{ch: field[k], last: (k == n - 1), truncated: cut,
                                bad_radix: 1'b0});
    end
  endfunction

  task automatic send_item(input logic [63:0] value, input logic [BASE_W-1:0] radix,
                           input logic [FMT_W-1:0] min_width,
                           input logic [FMT_W-1:0] min_digits,
                           input logic [FLG_W-1:0] flags);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[63:0] = value;
    word[RADIX_LSB +: BASE_W] = radix;
    word[MIN_WID_LSB +: FMT_W] = min_width;
    word[MIN_DIG_LSB +: FMT_W] = min_digits;
    word[FLAGS_LSB +: FLG_W] = flags;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    format_conversion(value, radix, min_width, min_digits, flags);
    n_items++;
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected item: ch %h last %b tuser %b", m_axis_tdata, m_axis_tlast,
               m_axis_tuser);
        n_errors++;
      end else begin
        want = pending_chars.pop_front();
        n_chars++;
        if (m_axis_tdata !== want.ch) begin
          $error("ch mismatch: expected %h, got %h", want.ch, m_axis_tdata);
          n_errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last mismatch: expected %b, got %b", want.last, m_axis_tlast);
          n_errors++;
        end
        if (m_axis_tuser[TUSER_TRUNC] !== want.truncated) begin
          $error("truncated mismatch: expected %b, got %b", want.truncated,
                 m_axis_tuser[TUSER_TRUNC]);
          n_errors++;
        end
        if (m_axis_tuser[TUSER_BAD] !== want.bad_radix) begin
          $error("bad_radix mismatch: expected %b, got %b", want.bad_radix,
                 m_axis_tuser[TUSER_BAD]);
          n_errors++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_item(64'd0, RADIX_DEC, 7'd0, 7'd0, F_NONE);
    send_item('1, RADIX_BIN, 7'd0, 7'd0, F_NONE);
    send_item('1, RADIX_MAX, 7'd0, 7'd0, F_UPPER);
    send_item(MOST_NEG, RADIX_DEC, 7'd0, 7'd0, F_SIGN);
    send_item(64'd0, RADIX_HEX, 7'd0, 7'd0, F_ALT);
    send_item(64'd255, RADIX_HEX, 7'd10, 7'd0, F_ALT | F_ZPAD | F_UPPER);
  endtask

  task automatic test_sign_flags();
    send_item(-64'sd42, RADIX_DEC, 7'd0, 7'd0, F_SIGN | F_PLUS);
    send_item(64'd42, RADIX_DEC, 7'd6, 7'd0, F_SIGN | F_PLUS);
    send_item(64'd42, RADIX_DEC, 7'd0, 7'd4, F_SIGN | F_SPACE);
    send_item(-64'sd7, RADIX_DEC, 7'd0, 7'd0, F_PLUS | F_SPACE);
    send_item(-64'sd123, RADIX_DEC, 7'd20, 7'd0, F_SIGN | F_LEFT);
    send_item(64'd99, RADIX_DEC, 7'd12, 7'd0, F_SIGN | F_SPACE | F_ZPAD);
  endtask

  task automatic test_prefix();
    send_item(64'd8, RADIX_OCT, 7'd0, 7'd0, F_ALT);
    send_item(64'd1234, RADIX_DEC, 7'd8, 7'd0, F_ALT);
    send_item(64'hdead_beef, RADIX_HEX, 7'd0, 7'd12, F_ALT);
    send_item(64'hcafe, RADIX_HEX, 7'd64, 7'd0, F_ALT | F_LEFT);
  endtask

  task automatic test_bad_radix();
    send_item(64'd5, 6'd0, 7'd10, 7'd3, F_SIGN);
    send_item(64'd5, 6'd1, 7'd0, 7'd0, F_NONE);
    send_item(64'd5, 6'd37, 7'd0, 7'd0, F_ALT);
    send_item('1, 6'd63, 7'd64, 7'd64, '1);
  endtask

  task automatic test_char_cap();
    send_item(-64'sd1, RADIX_DEC, 7'd64, 7'd0, F_SIGN | F_ZPAD);
    send_item(-64'sd1, RADIX_DEC, 7'd0, 7'd64, F_SIGN);
    send_item(64'o777, RADIX_OCT, 7'd0, 7'd64, F_ALT);
    send_item(64'd77, RADIX_DEC, 7'd30, 7'd0, F_LEFT | F_ZPAD);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct);
    logic [63:0]       value;
    logic [BASE_W-1:0] radix;
    logic [FMT_W-1:0]  min_width;
    logic [FMT_W-1:0]  min_digits;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      case ($urandom_range(0, 5))
        0: value = 64'($urandom_range(0, 1000));
        1: value = -64'($urandom_range(1, 1000));
        2: value = {$urandom, $urandom} >> $urandom_range(0, 63);
        3: value = ($urandom_range(0, 1) != 0) ? MOST_NEG : {$urandom, $urandom} | MOST_NEG;
        default: value = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 9))
        0: radix = ($urandom_range(0, 3) == 0) ? BASE_W'($urandom_range(0, 1))
                                               : BASE_W'($urandom_range(37, 63));
        1: radix = RADIX_BIN;
        2: radix = RADIX_OCT;
        3: radix = RADIX_DEC;
        4: radix = RADIX_HEX;
        5: radix = RADIX_MAX;
        default: radix = BASE_W'($urandom_range(2, 36));
      endcase
      min_width = ($urandom_range(0, 3) == 0) ? FMT_W'($urandom_range(0, 64))
                                              : FMT_W'($urandom_range(0, 16));
      min_digits = ($urandom_range(0, 4) == 0) ? FMT_W'($urandom_range(0, 64))
                                               : FMT_W'($urandom_range(0, 8));
      send_item(value, radix, min_width, min_digits, FLG_W'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_sign_flags();
    test_prefix();
    test_bad_radix();
    test_char_cap();
    test_random_traffic(50, 0, 0);
    test_random_traffic(50, 84, 0);
    test_random_traffic(50, 0, 84);
    test_random_traffic(50, 27, 27);
    send_idle_pct = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d conversions (%0d bad base, %0d cut at the cap) and checked %0d chars",
             n_items, n_bad, n_cut, n_chars);
    $display("under no idling, sender idling, receiver stalling and both; %0d mismatches.",
             n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- integer_to_ascii_formatter_top.f -----
+incdir+rtl/core
rtl/core/itoaf_pkg.sv
rtl/core/itoaf_cell.sv
rtl/core/itoaf_chain.sv
rtl/core/integer_to_ascii_formatter_top.sv
tb/integer_to_ascii_formatter_top_tb.sv
